>>> rtl/hslm_pkg.sv
// ----------------------------------------------------------------------------
// hslm_pkg
// Shared types and constants of the heater stability and limit monitor.
// ----------------------------------------------------------------------------
package hslm_pkg;

    localparam int CHECK_PERIOD = 5;
    localparam int PHASE_W      = (CHECK_PERIOD > 1) ? $clog2(CHECK_PERIOD) : 1;

    localparam int TEMP_W   = 16;
    localparam int TOL_W    = 10;
    localparam int DWELL_W  = 16;
    localparam int OPT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_OPTION  = 3'd4;

    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST  = 16'sd16000;
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST   = 16'sd0;
    localparam logic [TOL_W-1:0]         TOLERANCE_RST   = 10'd5;
    localparam logic [DWELL_W-1:0]       STABLE_TIME_RST = 16'd0;

    localparam logic [OPT_W-1:0] OPT_IGNORE  = 2'd0;
    localparam logic [OPT_W-1:0] OPT_WARNING = 2'd1;
    localparam logic [OPT_W-1:0] OPT_DISABLE = 2'd2;
    localparam logic [OPT_W-1:0] OPT_ABORT   = 2'd3;

    localparam logic [1:0] STATUS_STABLE   = 2'd0;
    localparam logic [1:0] STATUS_UNSTABLE = 2'd1;
    localparam logic [1:0] STATUS_MOVING   = 2'd2;

    localparam logic [1:0] LIM_NONE = 2'd0;
    localparam logic [1:0] LIM_HIGH = 2'd1;
    localparam logic [1:0] LIM_LOW  = 2'd2;

    typedef enum logic [2:0] {
        ST_STABLE   = 3'b001,
        ST_UNSTABLE = 3'b010,
        ST_MOVING   = 3'b100
    } status_t;

endpackage

>>> rtl/heater_stability_and_limit_monitor_top.sv
// ----------------------------------------------------------------------------
// heater_stability_and_limit_monitor_top
// Tracks heater settling on its setpoint and runs periodic fault checks.
// ----------------------------------------------------------------------------
// One word per one-second tick enters on the s_ side and gives exactly one
// result word on the m_ side. The block accepts a word in every clock cycle
// while the result side keeps taking words. Each word first sits in the
// input register, where the compare and counter logic works on it, and then
// lands in the result register, from which its result is offered. While a
// result word waits, one more word can wait in the input register before
// s_tready drops. Every CHECK_PERIOD-th word, starting with the first after
// reset, also carries the hardware error and temperature limit check. The
// user must write configuration through cfg_wr_en, cfg_addr and cfg_wdata
// only while no word is in flight; the block itself does not enforce this.
module heater_stability_and_limit_monitor_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hslm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [hslm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // temp_reading[15:0], temp_setpoint[31:16], hw_error_one[32],
    // hw_error_two[33], enter_moving[34], zero fill[39:35]
    input  logic [hslm_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // stable_status[1:0], check_done[2], hw_fault[3], limit_fault[5:4],
    // alarm_raised[6], chamber_disable[7], abort_interlock[8], zero fill[15:9]
    output logic [hslm_pkg::M_DATA_W-1:0]     m_tdata
);
    import hslm_pkg::*;

    logic signed [TEMP_W-1:0] high_limit_reg;
    logic signed [TEMP_W-1:0] low_limit_reg;
    logic [TOL_W-1:0]         tolerance_reg;
    logic [DWELL_W-1:0]       stable_time_reg;
    logic [OPT_W-1:0]         monitor_option_reg;

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] reading_reg;
    logic signed [TEMP_W-1:0] setpoint_reg;
    logic                     err_one_reg;
    logic                     err_two_reg;
    logic                     moving_req_reg;

    status_t                  status_reg, status_next;
    logic [DWELL_W-1:0]       dwell_reg, dwell_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;

    logic                     out_valid_reg;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_done_reg, out_done_next;
    logic                     out_hw_reg, out_hw_next;
    logic [1:0]               out_lim_reg, out_lim_next;
    logic                     out_alarm_reg, out_alarm_next;
    logic                     out_cdis_reg, out_cdis_next;
    logic                     out_abort_reg, out_abort_next;

    logic                     advance;
    logic signed [TEMP_W:0]   diff;
    logic [TEMP_W:0]          mag;
    logic [TEMP_W-4:0]        dev;
    logic                     outside;
    logic [DWELL_W-1:0]       dwell_inc;
    status_t                  status_pre;
    logic                     fault;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_limit_reg     <= HIGH_LIMIT_RST;
            low_limit_reg      <= LOW_LIMIT_RST;
            tolerance_reg      <= TOLERANCE_RST;
            stable_time_reg    <= STABLE_TIME_RST;
            monitor_option_reg <= OPT_IGNORE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_HIGH_LIMIT:  high_limit_reg     <= cfg_wdata;
                CFG_LOW_LIMIT:   low_limit_reg      <= cfg_wdata;
                CFG_TOLERANCE:   tolerance_reg      <= cfg_wdata[TOL_W-1:0];
                CFG_STABLE_TIME: stable_time_reg    <= cfg_wdata;
                CFG_MON_OPTION:  monitor_option_reg <= cfg_wdata[OPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            reading_reg    <= s_tdata[15:0];
            setpoint_reg   <= s_tdata[31:16];
            err_one_reg    <= s_tdata[32];
            err_two_reg    <= s_tdata[33];
            moving_req_reg <= s_tdata[34];
        end
    end

    always_comb begin
        diff    = {setpoint_reg[TEMP_W-1], setpoint_reg} - {reading_reg[TEMP_W-1], reading_reg};
        mag     = diff[TEMP_W] ? (~diff + 1'b1) : diff;
        dev     = mag[TEMP_W:4];
        outside = dev > {3'b000, tolerance_reg};

        dwell_inc  = (dwell_reg != '1) ? dwell_reg + 1'b1 : dwell_reg;
        status_pre = moving_req_reg ? ST_MOVING : status_reg;

        status_next = status_pre;
        dwell_next  = dwell_inc;
        case (status_pre)
            ST_STABLE: begin
                if (outside) begin
                    status_next = ST_UNSTABLE;
                    dwell_next  = '0;
                end
            end
            ST_UNSTABLE: begin
                if (outside) begin
                    dwell_next = '0;
                end else if (dwell_inc >= stable_time_reg) begin
                    status_next = ST_STABLE;
                end
            end
            default: begin
                if (!outside) begin
                    status_next = ST_UNSTABLE;
                    dwell_next  = '0;
                end
            end
        endcase

        case (status_next)
            ST_STABLE:   out_status_next = STATUS_STABLE;
            ST_UNSTABLE: out_status_next = STATUS_UNSTABLE;
            default:     out_status_next = STATUS_MOVING;
        endcase

        phase_next = (phase_reg == PHASE_W'(CHECK_PERIOD - 1)) ? '0 : phase_reg + 1'b1;

        out_done_next  = (phase_reg == '0);
        out_hw_next    = 1'b0;
        out_lim_next   = LIM_NONE;
        out_alarm_next = 1'b0;
        out_cdis_next  = 1'b0;
        out_abort_next = 1'b0;
        fault          = 1'b0;
        if (out_done_next) begin
            out_hw_next = err_one_reg | err_two_reg;
            if (reading_reg > high_limit_reg) begin
                out_lim_next = LIM_HIGH;
            end else if (reading_reg < low_limit_reg) begin
                out_lim_next = LIM_LOW;
            end
            fault          = out_hw_next || (out_lim_next != LIM_NONE);
            out_alarm_next = fault && (monitor_option_reg != OPT_IGNORE);
            out_cdis_next  = fault && (monitor_option_reg == OPT_DISABLE);
            out_abort_next = fault && (monitor_option_reg == OPT_ABORT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_STABLE;
            dwell_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                status_reg <= status_next;
                dwell_reg  <= dwell_next;
                phase_reg  <= phase_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= out_status_next;
            out_done_reg   <= out_done_next;
            out_hw_reg     <= out_hw_next;
            out_lim_reg    <= out_lim_next;
            out_alarm_reg  <= out_alarm_next;
            out_cdis_reg   <= out_cdis_next;
            out_abort_reg  <= out_abort_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_abort_reg, out_cdis_reg, out_alarm_reg,
                       out_lim_reg, out_hw_reg, out_done_reg, out_status_reg};

endmodule

>>> rtl/hslm_checker.sv
// ----------------------------------------------------------------------------
// hslm_checker
// Port-level checks of the heater stability and limit monitor.
// ----------------------------------------------------------------------------
module hslm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hslm_pkg::M_DATA_W-1:0]   m_tdata
);
    import hslm_pkg::*;

    // A word without a check carries no fault or effect flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[8:3] == 6'b000000)
        else $error("fault flags set on a word without a check");

    // Effects follow the alarm and never both at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7] || m_tdata[8]) |-> m_tdata[6] && !(m_tdata[7] && m_tdata[8]))
        else $error("effect flag without alarm or both effects set");

    // Status and limit codes stay within their defined values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[5:4] != 2'd3)
        else $error("undefined status or limit code");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind heater_stability_and_limit_monitor_top hslm_checker u_hslm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
